// File: src/psu_pkg.sv
// ============================================================================
// psu_pkg: shared types and constants for the PNG scanline unfilter
// Beat formats, register indexes, filter, colour and status codes.
// ============================================================================
package psu_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int QUEUE_DEPTH = 2;
	localparam int LANES       = 4;
	localparam int LW_W        = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 11;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_TYPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd1;

	localparam logic [2:0] CT_GRAY       = 3'd0;
	localparam logic [2:0] CT_RGB        = 3'd2;
	localparam logic [2:0] CT_PALETTE    = 3'd3;
	localparam logic [2:0] CT_GRAY_ALPHA = 3'd4;
	localparam logic [2:0] CT_RGBA       = 3'd6;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_FILTER = 2'd1;
	localparam logic [1:0] ST_BAD_COLOR  = 2'd2;

	typedef struct packed {
		logic [7:0] filtered_byte;
		logic       image_start;
	} byte_beat_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       last_in_line;
		logic [1:0] status;
	} pix_beat_t;

	// One classified operation handed from the front to the back.
	typedef struct packed {
		logic       is_err;
		logic [1:0] status;
		logic [7:0] data;
		logic [2:0] filt;
		logic       first_px;
		logic       first_row;
		logic       last;
		logic [1:0] chm1;
	} op_t;

endpackage

// File: src/png_scanline_unfilter.sv
// A data byte passes the queue and the stage-one register, and its result is held
// in the output register. Throughput: one byte per cycle while the queue has room;
// a valid filter-type byte gives no beat. The rate is set by the predictor loop,
// which reuses the result one pixel back as left neighbor, and by one line-store
// read and write a cycle. Reset sets the control state and configuration registers
// to defaults; the line store is not cleared, and is used from the second row on.
// ============================================================================
// png_scanline_unfilter: PNG filter reconstruction, one byte per beat
// A classifier front end feeds a short queue; the back end reconstructs bytes
// with the none, sub, up, average and Paeth predictors.
// ============================================================================
module png_scanline_unfilter #(
	parameter int MAX_WIDTH   = psu_pkg::MAX_WIDTH,
	parameter int QUEUE_DEPTH = psu_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	output logic                           byte_ready,
	input  psu_pkg::byte_beat_t            byte_beat,
	output logic                           pix_valid,
	input  logic                           pix_ready,
	output psu_pkg::pix_beat_t             pix_beat,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W  = $clog2(psu_pkg::LANES * MAX_WIDTH);
	localparam int OP_W    = $bits(psu_pkg::op_t);
	localparam int ENTRY_W = OP_W + ADDR_W;

	logic               push;
	psu_pkg::op_t       push_op;
	logic [ADDR_W-1:0]  push_idx;
	logic               pop;
	logic [ENTRY_W-1:0] head_data;
	psu_pkg::op_t       head_op;
	logic [ADDR_W-1:0]  head_idx;
	logic               q_full;
	logic               q_empty;

	assign cfg_ready = 1'b1;
	assign head_op   = psu_pkg::op_t'(head_data[ENTRY_W-1:ADDR_W]);
	assign head_idx  = head_data[ADDR_W-1:0];

	psu_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.ADDR_W    (ADDR_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_beat  (byte_beat),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.push       (push),
		.push_op    (push_op),
		.push_idx   (push_idx)
	);

	psu_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_op, push_idx}),
		.pop       (pop),
		.head_data (head_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	psu_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.ADDR_W    (ADDR_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_op   (head_op),
		.head_idx  (head_idx),
		.q_empty   (q_empty),
		.pop       (pop),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_beat  (pix_beat)
	);

`ifndef SYNTHESIS
	a_err_beat_blank: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_beat.status != psu_pkg::ST_OK
		|-> pix_beat.pixel_byte == 8'd0 && !pix_beat.last_in_line)
		else $error("error beat carries pixel data");

	a_status_known: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> pix_beat.status == psu_pkg::ST_OK
			|| pix_beat.status == psu_pkg::ST_BAD_FILTER
			|| pix_beat.status == psu_pkg::ST_BAD_COLOR)
		else $error("unknown status code on output");

	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> !q_empty)
		else $error("input stalled with an empty queue");
`endif

endmodule

// File: src/psu_queue.sv
// ============================================================================
// psu_queue: short FIFO between the classifier and the reconstruction pipe
// Head entry is presented combinationally; push and pop may share a cycle.
// ============================================================================
module psu_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = psu_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/psu_front.sv
// ============================================================================
// psu_front: byte classifier for the PNG scanline unfilter
// Holds the configuration registers and row bookkeeping; each accepted byte
// but a valid filter type becomes a data or error operation for the back end.
// ============================================================================
module psu_front #(
	parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH,
	parameter int ADDR_W    = $clog2(psu_pkg::LANES * MAX_WIDTH)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_ready,
	input  psu_pkg::byte_beat_t                 byte_beat,
	input  logic                                cfg_valid,
	input  logic [psu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                q_full,
	output logic                                push,
	output psu_pkg::op_t                        push_op,
	output logic [ADDR_W-1:0]                   push_idx
);

	localparam int POS_W = $clog2(psu_pkg::LANES * MAX_WIDTH + 1);
	localparam int CMP_W = (POS_W > psu_pkg::LW_W) ? POS_W : psu_pkg::LW_W;

	logic [2:0]               color_q;
	logic [psu_pkg::LW_W-1:0] width_q;
	logic [POS_W-1:0]         pos_q;
	logic [2:0]               filt_q;
	logic                     first_q;
	logic [1:0]               err_q;

	logic             accept;
	logic [1:0]       e_err;
	logic [POS_W-1:0] e_pos;
	logic             e_first;
	logic             ch_ok;
	logic [1:0]       chm1;
	logic [CMP_W-1:0] lw_ext;
	logic [POS_W-1:0] eff_w;
	logic [POS_W-1:0] bpl;
	logic [POS_W-1:0] idx_full;
	logic             last;
	logic             bad_filter;

	assign byte_ready = !q_full;
	assign accept     = byte_valid && !q_full;

	// An image start clears the row state before the byte itself is handled.
	assign e_err   = byte_beat.image_start ? psu_pkg::ST_OK : err_q;
	assign e_pos   = byte_beat.image_start ? '0 : pos_q;
	assign e_first = byte_beat.image_start || first_q;

	always_comb begin
		ch_ok = 1'b1;
		chm1  = 2'd0;
		unique case (color_q) inside
			psu_pkg::CT_GRAY, psu_pkg::CT_PALETTE: chm1 = 2'd0;
			psu_pkg::CT_GRAY_ALPHA:                chm1 = 2'd1;
			psu_pkg::CT_RGB:                       chm1 = 2'd2;
			psu_pkg::CT_RGBA:                      chm1 = 2'd3;
			default:                               ch_ok = 1'b0;
		endcase
	end

	assign lw_ext = CMP_W'(width_q);

	always_comb begin
		if (width_q == '0) begin
			eff_w = POS_W'(1);
		end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
			eff_w = POS_W'(MAX_WIDTH);
		end else begin
			eff_w = POS_W'(lw_ext);
		end
	end

	always_comb begin
		case (chm1)
			2'd0:    bpl = eff_w;
			2'd1:    bpl = eff_w << 1;
			2'd2:    bpl = eff_w + (eff_w << 1);
			default: bpl = eff_w << 2;
		endcase
	end

	assign idx_full   = e_pos - 1'b1;
	assign last       = (e_pos >= bpl);
	assign bad_filter = (byte_beat.filtered_byte > {5'd0, psu_pkg::FILT_PAETH});

	always_comb begin
		push_op.is_err    = 1'b1;
		push_op.status    = psu_pkg::ST_OK;
		push_op.data      = byte_beat.filtered_byte;
		push_op.filt      = filt_q;
		push_op.first_px  = (idx_full <= POS_W'(chm1));
		push_op.first_row = e_first;
		push_op.last      = last;
		push_op.chm1      = chm1;
		push              = accept;
		if (e_err != psu_pkg::ST_OK) begin
			push_op.status = e_err;
		end else if (!ch_ok) begin
			push_op.status = psu_pkg::ST_BAD_COLOR;
		end else if (e_pos == '0) begin
			push_op.status = psu_pkg::ST_BAD_FILTER;
			push           = accept && bad_filter;
		end else begin
			push_op.is_err = 1'b0;
		end
	end

	assign push_idx = idx_full[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= psu_pkg::CT_GRAY;
			width_q <= psu_pkg::LW_W'(1);
			pos_q   <= '0;
			filt_q  <= psu_pkg::FILT_NONE;
			first_q <= 1'b1;
			err_q   <= psu_pkg::ST_OK;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == psu_pkg::REG_COLOR_TYPE) begin
					color_q <= cfg_data[2:0];
				end else begin
					width_q <= cfg_data[psu_pkg::LW_W-1:0];
				end
			end
			if (accept) begin
				err_q   <= e_err;
				pos_q   <= e_pos;
				first_q <= e_first;
				if (e_err != psu_pkg::ST_OK) begin
					// Error holds until the next image start.
				end else if (!ch_ok) begin
					err_q <= psu_pkg::ST_BAD_COLOR;
				end else if (e_pos == '0) begin
					if (bad_filter) begin
						err_q <= psu_pkg::ST_BAD_FILTER;
					end else begin
						filt_q <= byte_beat.filtered_byte[2:0];
						pos_q  <= POS_W'(1);
					end
				end else if (last) begin
					pos_q   <= '0;
					first_q <= 1'b0;
				end else begin
					pos_q <= e_pos + 1'b1;
				end
			end
		end
	end

endmodule

// File: src/psu_back.sv
// ============================================================================
// psu_back: reconstruction pipe for the PNG scanline unfilter
// Reads the prior row from the line store, applies the filter predictor,
// writes the new row back and holds the result in an output register.
// ============================================================================
module psu_back #(
	parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH,
	parameter int ADDR_W    = $clog2(psu_pkg::LANES * MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  psu_pkg::op_t        head_op,
	input  logic [ADDR_W-1:0]   head_idx,
	input  logic                q_empty,
	output logic                pop,
	output logic                pix_valid,
	input  logic                pix_ready,
	output psu_pkg::pix_beat_t  pix_beat
);

	localparam int STORE_DEPTH = psu_pkg::LANES * MAX_WIDTH;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [7:0] pa;
		logic [7:0] pb;
		logic [8:0] ab;
		logic [8:0] c2;
		logic [8:0] pc;
		ab = {1'b0, a} + {1'b0, b};
		c2 = {c, 1'b0};
		pa = (b > c) ? b - c : c - b;
		pb = (a > c) ? a - c : c - a;
		pc = (ab > c2) ? ab - c2 : c2 - ab;
		if (pa <= pb && {1'b0, pa} <= pc) begin
			return a;
		end else if ({1'b0, pb} <= pc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

	logic [7:0] store_q [STORE_DEPTH];

	logic               valid_s1;
	psu_pkg::op_t       op_s1;
	logic [ADDR_W-1:0]  idx_s1;
	logic [7:0]         up_rd_s1;
	logic               fwd_s1;
	logic [7:0]         fwd_byte_s1;
	logic [7:0]         left_q [psu_pkg::LANES];
	logic [7:0]         upleft_q [psu_pkg::LANES];
	logic               out_valid_q;
	psu_pkg::pix_beat_t out_beat_q;

	logic       adv;
	logic       wr;
	logic [7:0] up_raw;
	logic [7:0] up;
	logic [7:0] left;
	logic [7:0] upleft;
	logic [8:0] sum_lu;
	logic [7:0] pred;
	logic [7:0] rec;
	psu_pkg::pix_beat_t result;

	assign adv       = !out_valid_q || pix_ready;
	assign pop       = adv && !q_empty;
	assign wr        = adv && valid_s1 && !op_s1.is_err;
	assign pix_valid = out_valid_q;
	assign pix_beat  = out_beat_q;

	// A row of one byte reads the entry written in the same cycle, so that
	// value is carried forward instead of the stale store output.
	assign up_raw = fwd_s1 ? fwd_byte_s1 : up_rd_s1;
	assign up     = op_s1.first_row ? 8'd0 : up_raw;
	assign left   = op_s1.first_px ? 8'd0 : left_q[op_s1.chm1];
	assign upleft = (op_s1.first_row || op_s1.first_px) ? 8'd0 : upleft_q[op_s1.chm1];
	assign sum_lu = {1'b0, left} + {1'b0, up};

	always_comb begin
		case (op_s1.filt)
			psu_pkg::FILT_SUB:   pred = left;
			psu_pkg::FILT_UP:    pred = up;
			psu_pkg::FILT_AVG:   pred = sum_lu[8:1];
			psu_pkg::FILT_PAETH: pred = paeth(left, up, upleft);
			default:             pred = 8'd0;
		endcase
	end

	assign rec = op_s1.data + pred;

	always_comb begin
		if (op_s1.is_err) begin
			result.pixel_byte   = 8'd0;
			result.last_in_line = 1'b0;
			result.status       = op_s1.status;
		end else begin
			result.pixel_byte   = rec;
			result.last_in_line = op_s1.last;
			result.status       = psu_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[idx_s1] <= rec;
		end
		if (pop) begin
			up_rd_s1 <= store_q[head_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1       <= head_op;
			idx_s1      <= head_idx;
			fwd_byte_s1 <= rec;
		end
		if (adv) begin
			out_beat_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < psu_pkg::LANES; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else begin
			if (adv) begin
				valid_s1    <= !q_empty;
				out_valid_q <= valid_s1;
			end
			if (pop) begin
				fwd_s1 <= wr && (idx_s1 == head_idx);
			end
			if (wr) begin
				left_q[0]   <= rec;
				upleft_q[0] <= up;
				for (int i = 1; i < psu_pkg::LANES; i++) begin
					left_q[i]   <= left_q[i-1];
					upleft_q[i] <= upleft_q[i-1];
				end
			end
		end
	end

endmodule

// File: tb/sv/testbench.sv
// ============================================================================
// testbench: self-checking bench for png_scanline_unfilter
// A scoreboard class predicts every output beat from the accepted byte beats.
// The stimulus is a short directed run of each filter, error and register
// change, then random images under three ready/valid idling regimes.
// ============================================================================
module testbench;
	import psu_pkg::*;

	localparam logic [2:0] CT_RESERVED  = 3'd7;
	localparam int         STORE_BYTES  = MAX_WIDTH * LANES;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         PHASES       = 12;

	class unfilter_scoreboard;
		pix_beat_t   expected_pixels[$];
		logic [7:0]  line_store[STORE_BYTES];
		logic [7:0]  left_hist[LANES];
		logic [7:0]  upleft_hist[LANES];
		int unsigned line_pos;
		logic [2:0]  filt;
		bit          first_row;
		logic [1:0]  err;
		logic [2:0]  color;
		logic [LW_W-1:0] width;
		int          failures;

		function new();
			foreach (line_store[i]) line_store[i] = '0;
			left_hist = '{default: '0};
			upleft_hist = '{default: '0};
			line_pos = 0;
			filt = FILT_NONE;
			first_row = 1'b1;
			err = ST_OK;
			color = CT_GRAY;
			width = LW_W'(1);
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_COLOR_TYPE)
				color = data[2:0];
			else
				width = data[LW_W-1:0];
		endfunction

		function int channels();
			case (color)
				CT_GRAY, CT_PALETTE: return 1;
				CT_GRAY_ALPHA:       return 2;
				CT_RGB:              return 3;
				CT_RGBA:             return 4;
				default:             return 0;
			endcase
		endfunction

		// Bytes per scanline after the width is clamped to 1..MAX_WIDTH.
		function int row_bytes();
			int w;
			w = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : int'(width));
			return w * channels();
		endfunction

		function int paeth_pick(int a, int b, int c);
			int pa, pb, pc;
			pa = (b > c) ? b - c : c - b;
			pb = (a > c) ? a - c : c - a;
			pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
			if (pa <= pb && pa <= pc)
				return a;
			if (pb <= pc)
				return b;
			return c;
		endfunction

		function void push_error();
			pix_beat_t r;
			r.pixel_byte = '0;
			r.last_in_line = 1'b0;
			r.status = err;
			expected_pixels.insert(expected_pixels.size(), r);
		endfunction

		function void note_byte(byte_beat_t b);
			pix_beat_t r;
			int ch, bpl, idx, left, up, ul, pred;
			bit first_px;
			logic [7:0] rec;
			if (b.image_start) begin
				err = ST_OK;
				line_pos = 0;
				first_row = 1'b1;
				left_hist = '{default: '0};
				upleft_hist = '{default: '0};
			end
			if (err != ST_OK) begin
				push_error();
				return;
			end
			ch = channels();
			if (ch == 0) begin
				err = ST_BAD_COLOR;
				push_error();
				return;
			end
			// Position zero means this beat carries the filter type of a new row.
			if (line_pos == 0) begin
				if (b.filtered_byte > FILT_PAETH) begin
					err = ST_BAD_FILTER;
					push_error();
					return;
				end
				filt = b.filtered_byte[2:0];
				line_pos = 1;
				return;
			end
			bpl = row_bytes();
			idx = line_pos - 1;
			if (idx >= STORE_BYTES)
				idx = STORE_BYTES - 1;
			first_px = idx < ch;
			up = first_row ? 0 : int'(line_store[idx]);
			left = first_px ? 0 : int'(left_hist[ch-1]);
			ul = (first_row || first_px) ? 0 : int'(upleft_hist[ch-1]);
			case (filt)
				FILT_SUB:   pred = left;
				FILT_UP:    pred = up;
				FILT_AVG:   pred = (left + up) >> 1;
				FILT_PAETH: pred = paeth_pick(left, up, ul);
				default:    pred = 0;
			endcase
			rec = 8'(int'(b.filtered_byte) + pred);
			for (int i = LANES - 1; i > 0; i--) begin
				left_hist[i] = left_hist[i-1];
				upleft_hist[i] = upleft_hist[i-1];
			end
			left_hist[0] = rec;
			upleft_hist[0] = 8'(up);
			line_store[idx] = rec;
			r.pixel_byte = rec;
			r.last_in_line = (line_pos >= bpl);
			r.status = ST_OK;
			expected_pixels.insert(expected_pixels.size(), r);
			if (r.last_in_line) begin
				line_pos = 0;
				first_row = 1'b0;
			end else begin
				line_pos++;
			end
		endfunction

		function void check_pixel(pix_beat_t got);
			pix_beat_t want;
			if (expected_pixels.size() == 0) begin
				$error("pixel beat with none expected: pixel_byte %0h last_in_line %0b status %0d",
					got.pixel_byte, got.last_in_line, got.status);
				failures++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got.pixel_byte !== want.pixel_byte) begin
				$error("pixel_byte: expected %0h, got %0h", want.pixel_byte, got.pixel_byte);
				failures++;
			end
			if (got.last_in_line !== want.last_in_line) begin
				$error("last_in_line: expected %0b, got %0b", want.last_in_line,
					got.last_in_line);
				failures++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				failures++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_ready;
	byte_beat_t            byte_beat = '0;
	logic                  pix_valid;
	logic                  pix_ready = 1'b0;
	pix_beat_t             pix_beat;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	unfilter_scoreboard sb = new();
	int byte_gap_pct = 20;
	int ready_stall_pct = 68;
	int bytes_left = 0;

	png_scanline_unfilter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_beat (byte_beat),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_beat  (pix_beat),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && pix_valid && pix_ready)
			sb.check_pixel(pix_beat);
		pix_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
	end

	task automatic send_byte(input logic [7:0] value, input logic start);
		byte_beat_t b;
		b.filtered_byte = value;
		b.image_start = start;
		while ($urandom_range(0, 99) < byte_gap_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat <= b;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		sb.note_byte(b);
		if (bytes_left > 0)
			bytes_left--;
	endtask

	// Holds the byte channel idle until every predicted beat has come out.
	task automatic settle();
		byte_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [2:0] ct, input logic [CFG_DATA_W-1:0] w);
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		for (int i = 0; i < 2; i++) begin
			idx = (i == 0) ? REG_COLOR_TYPE : REG_LINE_WIDTH;
			val = (i == 0) ? CFG_DATA_W'(ct) : w;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.write_reg(idx, val);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_sample();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] rand_filter(bit noisy);
		if (noisy && $urandom_range(0, 19) == 0)
			return 8'($urandom_range(FILT_PAETH + 1, 255));
		return 8'($urandom_range(FILT_NONE, FILT_PAETH));
	endfunction

	task automatic send_image(input bit noisy);
		int rows, bpl, n;
		logic [7:0] f;
		rows = $urandom_range(1, 4);
		bpl = sb.row_bytes();
		for (int r = 0; r < rows && bytes_left > 0; r++) begin
			f = rand_filter(noisy);
			send_byte(f, r == 0);
			// A bad filter locks the error status; a few more beats show it holds.
			if (f > FILT_PAETH) begin
				repeat ($urandom_range(1, 4)) send_byte(rand_sample(), 1'b0);
				return;
			end
			n = bpl;
			if (noisy && $urandom_range(0, 15) == 0)
				n = $urandom_range(0, bpl - 1);
			for (int i = 0; i < n && bytes_left > 0; i++)
				send_byte(rand_sample(), 1'b0);
			if (n < bpl)
				return;
		end
	endtask

	task automatic run_phase(input int budget, input bit noisy);
		bit paused;
		paused = 1'b0;
		bytes_left = budget;
		while (bytes_left > 0) begin
			if (sb.row_bytes() == 0) begin
				send_byte(rand_sample(), $urandom_range(0, 3) == 0);
			end else begin
				send_image(noisy);
				if (!paused) begin
					settle();
					paused = 1'b1;
				end
			end
		end
	endtask

	initial begin
		logic [2:0] ct;
		logic [CFG_DATA_W-1:0] w;
		int budget;
		bit noisy;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two channels, two pixels: each filter once, with the byte extremes.
		configure(CT_GRAY_ALPHA, CFG_DATA_W'(2));
		send_byte(8'(FILT_SUB), 1'b1);
		send_byte(8'hff, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0); send_byte(8'hff, 1'b0);
		send_byte(8'(FILT_UP), 1'b0);
		send_byte(8'h01, 1'b0); send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0); send_byte(8'h7f, 1'b0);
		send_byte(8'(FILT_AVG), 1'b0);
		send_byte(8'hff, 1'b0); send_byte(8'hff, 1'b0);
		send_byte(8'h01, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(8'(FILT_PAETH), 1'b0);
		send_byte(8'h10, 1'b0); send_byte(8'hf0, 1'b0);
		send_byte(8'h33, 1'b0); send_byte(8'hcc, 1'b0);
		// Filter type just past the last valid one, then an image start that
		// clears the error but brings another bad filter.
		send_byte(8'(FILT_PAETH + 1), 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'(FILT_NONE), 1'b1);
		send_byte(8'hab, 1'b0);
		settle();

		configure(CT_RESERVED, CFG_DATA_W'(1));
		send_byte(8'(FILT_NONE), 1'b1);
		send_byte(8'h00, 1'b0);
		settle();

		// Narrowing the row while past the new end closes the row on the next beat.
		configure(CT_GRAY, CFG_DATA_W'(3));
		send_byte(8'(FILT_SUB), 1'b1);
		send_byte(8'h05, 1'b0); send_byte(8'hfe, 1'b0); send_byte(8'h40, 1'b0);
		send_byte(8'(FILT_UP), 1'b0);
		send_byte(8'h11, 1'b0); send_byte(8'h22, 1'b0);
		settle();
		configure(CT_GRAY, CFG_DATA_W'(1));
		send_byte(8'h33, 1'b0);
		send_byte(8'(FILT_AVG), 1'b0);
		send_byte(8'h44, 1'b0);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			byte_gap_pct = (ph < 4) ? 20 : ((ph < 8) ? 68 : 0);
			ready_stall_pct = (ph < 4) ? 68 : ((ph < 8) ? 20 : 0);
			settle();
			noisy = 1'b1;
			if (ph == 9) begin
				// One full row at the widest setting, then part of another row.
				ct = CT_GRAY;
				case ($urandom_range(0, 2))
					0:       w = CFG_DATA_W'(MAX_WIDTH);
					1:       w = CFG_DATA_W'(MAX_WIDTH + 1);
					default: w = '1;
				endcase
				budget = MAX_WIDTH + 25;
				noisy = 1'b0;
			end else if (ph == 2 || ph == 6) begin
				do ct = 3'($urandom); while (ct == CT_GRAY || ct == CT_RGB ||
					ct == CT_PALETTE || ct == CT_GRAY_ALPHA || ct == CT_RGBA);
				w = CFG_DATA_W'($urandom_range(1, 8));
				budget = 16;
			end else begin
				case ($urandom_range(0, 4))
					0:       ct = CT_GRAY;
					1:       ct = CT_PALETTE;
					2:       ct = CT_GRAY_ALPHA;
					3:       ct = CT_RGB;
					default: ct = CT_RGBA;
				endcase
				w = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 12));
				budget = 100;
			end
			configure(ct, w);
			run_phase(budget, noisy);
		end

		settle();
		if (sb.failures == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: png_scanline_unfilter.f
src/psu_pkg.sv
src/psu_queue.sv
src/psu_front.sv
src/psu_back.sv
src/png_scanline_unfilter.sv
tb/sv/testbench.sv
